/* sv/bss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants of the bounded sorted set.
// ----------------------------------------------------------------------------
package bss_pkg;

    localparam int MAX_ENTRIES    = 128;
    localparam int CNT_W          = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W          = (CNT_W > 8) ? CNT_W : 8;
    localparam int GRP_SIZE       = 16;
    localparam int NUM_GRP        = (MAX_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
    localparam logic [7:0] CAPACITY_RESET = 8'd100;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_READ   = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef struct packed {
        logic               cmp_en;
        logic               shift_en;
        logic signed [31:0] value;
    } cell_ctrl_t;

endpackage

/* sv/bss_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_if
// Request, result and capacity write channels of the bounded sorted set.
// ----------------------------------------------------------------------------
interface bss_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [6:0]         index;

    modport source (output valid, kind, value, index, input ready);
    modport sink   (input valid, kind, value, index, output ready);
endinterface

interface bss_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [7:0]         count;

    modport source (output valid, status, element, count, input ready);
    modport sink   (input valid, status, element, count, output ready);
endinterface

interface bss_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* sv/bss_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_cell
// One slot of the sorted row: compares the broadcast value with its entry
// and, when the row shifts up, takes its lower neighbor's entry or the new value.
// ----------------------------------------------------------------------------
module bss_cell
    import bss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic               occupied,
    input  logic               prev_gt,
    input  logic signed [31:0] prev_entry,
    output logic signed [31:0] entry,
    output logic               gt,
    output logic               eq
);

    logic signed [31:0] entry_reg;
    logic               gt_reg;
    logic               eq_reg;

    // flags: empty slots count as greater than any value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            gt_reg <= !occupied || (ctrl.value < entry_reg);
            eq_reg <= occupied && (ctrl.value == entry_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en && gt_reg)
        begin
            entry_reg <= prev_gt ? prev_entry : ctrl.value;
        end
    end

    assign entry = entry_reg;
    assign gt    = gt_reg;
    assign eq    = eq_reg;

endmodule

/* sv/bss_reduce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_reduce
// Registered two-level tree over the cell row: membership and read select.
// ----------------------------------------------------------------------------
module bss_reduce
    import bss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [6:0]         index,
    input  logic               eq_row [MAX_ENTRIES],
    input  logic signed [31:0] entry_row [MAX_ENTRIES],
    output logic               present,
    output logic signed [31:0] element
);

    logic               grp_eq_reg   [NUM_GRP];
    logic               grp_eq_next  [NUM_GRP];
    logic signed [31:0] grp_elem_reg [NUM_GRP];
    logic signed [31:0] grp_elem_next[NUM_GRP];

    // first level: one group of cells each
    always_comb
    begin
        for (int g = 0; g < NUM_GRP; g++)
        begin
            grp_eq_next[g]   = 1'b0;
            grp_elem_next[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++)
            begin
                if (g * GRP_SIZE + j < MAX_ENTRIES)
                begin
                    grp_eq_next[g] = grp_eq_next[g] | eq_row[g * GRP_SIZE + j];
                    if (int'(index) % GRP_SIZE == j)
                    begin
                        grp_elem_next[g] = entry_row[g * GRP_SIZE + j];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NUM_GRP; g++)
            begin
                grp_eq_reg[g] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int g = 0; g < NUM_GRP; g++)
            begin
                grp_eq_reg[g] <= grp_eq_next[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int g = 0; g < NUM_GRP; g++)
            begin
                grp_elem_reg[g] <= grp_elem_next[g];
            end
        end
    end

    // second level: across groups
    always_comb
    begin
        present = 1'b0;
        element = '0;
        for (int g = 0; g < NUM_GRP; g++)
        begin
            present = present | grp_eq_reg[g];
            if (int'(index) / GRP_SIZE == g)
            begin
                element = grp_elem_reg[g];
            end
        end
    end

endmodule

/* sv/bounded_sorted_set.sv */
`timescale 1ns / 1ps
// result: registered at commit, after the compare and reduce states
// requests: one at a time, each through compare, reduce, then shift/commit (held while a result waits)
// an insert moves the cells above its insertion point up by one slot in its commit cycle
// reset: count cleared, capacity 100, entries left as they are
// the result register frees the request side while a result waits
// ----------------------------------------------------------------------------
// bounded_sorted_set
// Set of distinct signed 32-bit values kept ascending in a row of cells.
// ----------------------------------------------------------------------------
module bounded_sorted_set
    import bss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bss_req_if.sink   in,
    bss_rsp_if.source out,
    bss_cfg_if.sink   cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RED,
        S_DONE
    } state_t;

    state_t             state_reg;
    kind_t              kind_reg;
    logic signed [31:0] value_reg;
    logic [6:0]         index_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [7:0]         cap_reg;
    logic               out_valid_reg;
    status_t            status_reg;
    status_t            status_next;
    logic signed [31:0] element_reg;
    logic signed [31:0] element_next;
    logic [7:0]         count_reg;

    cell_ctrl_t         ctrl;
    logic               occ_row   [MAX_ENTRIES];
    logic               gt_row    [MAX_ENTRIES];
    logic               eq_row    [MAX_ENTRIES];
    logic signed [31:0] entry_row [MAX_ENTRIES];
    logic               present;
    logic signed [31:0] rd_element;
    logic [CMP_W-1:0]   cap_lim;
    logic               full;
    logic               commit;

    assign in.ready  = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign commit    = (state_reg == S_DONE) && (!out_valid_reg || out.ready);

    assign cap_lim = (CMP_W'(cap_reg) > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES)
                                                              : CMP_W'(cap_reg);
    assign full    = CMP_W'(cnt_reg) >= cap_lim;

    assign ctrl.cmp_en   = (state_reg == S_CMP);
    assign ctrl.shift_en = commit && (kind_reg == KIND_INSERT) && !full && !present;
    assign ctrl.value    = value_reg;

    generate
        for (genvar i = 0; i < MAX_ENTRIES; i++)
        begin : g_cell
            assign occ_row[i] = i < int'(cnt_reg);
            if (i == 0)
            begin : g_first
                bss_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .occupied   (occ_row[i]),
                    .prev_gt    (1'b0),
                    .prev_entry (value_reg),
                    .entry      (entry_row[i]),
                    .gt         (gt_row[i]),
                    .eq         (eq_row[i])
                );
            end
            else
            begin : g_next
                bss_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .occupied   (occ_row[i]),
                    .prev_gt    (gt_row[i-1]),
                    .prev_entry (entry_row[i-1]),
                    .entry      (entry_row[i]),
                    .gt         (gt_row[i]),
                    .eq         (eq_row[i])
                );
            end
        end
    endgenerate

    bss_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (state_reg == S_RED),
        .index     (index_reg),
        .eq_row    (eq_row),
        .entry_row (entry_row),
        .present   (present),
        .element   (rd_element)
    );

    always_comb
    begin
        status_next  = ST_OK;
        element_next = '0;
        cnt_next     = cnt_reg;
        case (kind_reg)
            KIND_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else if (present)
                begin
                    status_next = ST_PRESENT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            KIND_READ:
            begin
                if (CMP_W'(index_reg) < CMP_W'(cnt_reg))
                begin
                    element_next = rd_element;
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            KIND_CLEAR:
            begin
                cnt_next = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cap_reg       <= CAPACITY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                cap_reg <= cfg.data;
            end
            if (out_valid_reg && out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in.valid)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_RED;
                end
                S_RED:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (commit)
                    begin
                        state_reg     <= S_IDLE;
                        cnt_reg       <= cnt_next;
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (in.valid && in.ready)
        begin
            kind_reg  <= kind_t'(in.kind);
            value_reg <= in.value;
            index_reg <= in.index;
        end
        if (commit)
        begin
            status_reg  <= status_next;
            element_reg <= element_next;
            count_reg   <= 8'(cnt_next);
        end
    end

    assign out.valid   = out_valid_reg;
    assign out.status  = status_reg;
    assign out.element = element_reg;
    assign out.count   = count_reg;

endmodule

/* sv/bss_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_checker
// Port-level checks of the bounded sorted set, bound to the top level.
// ----------------------------------------------------------------------------
module bss_checker
    import bss_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_status,
    input logic [31:0] out_element,
    input logic [7:0]  out_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status)
            && $stable(out_element) && $stable(out_count))
        else $error("result changed while stalled");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(out_count) <= 32'(MAX_ENTRIES))
        else $error("count above set size");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == ST_RANGE |-> out_element == '0)
        else $error("out of range read with nonzero element");

    // one request in flight at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

endmodule

bind bounded_sorted_set bss_checker u_bss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in.valid),
    .in_ready    (in.ready),
    .out_valid   (out.valid),
    .out_ready   (out.ready),
    .out_status  (out.status),
    .out_element (out.element),
    .out_count   (out.count)
);
